// File: hdl/qlsf_pkg.sv
// Shared types and constants for the quadratic least-squares fit block.
// No dependencies.
package qlsf_pkg;

    localparam int XW             = 12;
    localparam int CNT_W          = 9;
    localparam int SX_W           = 20;
    localparam int SX2_W          = 32;
    localparam int SX3_W          = 43;
    localparam int SX4_W          = 54;
    localparam int SY_W           = 20;
    localparam int SXY_W          = 32;
    localparam int SX2Y_W         = 43;
    localparam int COEF_W         = 32;
    localparam int ST_W           = 2;
    localparam int MAX_POINTS_DEF = 256;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_SINGULAR = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic                 last;
        logic                 drop;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0]         cnt;
        logic signed [SX_W-1:0]   sx;
        logic signed [SX2_W-1:0]  sx2;
        logic signed [SX3_W-1:0]  sx3;
        logic signed [SX4_W-1:0]  sx4;
        logic signed [SY_W-1:0]   sy;
        logic signed [SXY_W-1:0]  sxy;
        logic signed [SX2Y_W-1:0] sx2y;
        logic                     dropped;
    } t_sums;

endpackage

// File: hdl/qlsf_front.sv
// Front end: accepts points, tracks the per-set count and marks overflow points.
// Depends on qlsf_pkg.
module qlsf_front #(
    parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic signed [qlsf_pkg::XW-1:0] i_x_value,
    input  logic signed [qlsf_pkg::XW-1:0] i_y_value,
    input  logic                         i_last_point,
    input  logic                         i_full,
    output logic                         busy,
    output logic                         o_push,
    output qlsf_pkg::t_item              o_item
);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] r_cnt;
    logic          w_drop;

    assign busy   = i_full;
    assign o_push = start && !i_full;
    assign w_drop = (r_cnt == CW'(MAX_POINTS));

    assign o_item.x    = i_x_value;
    assign o_item.y    = i_y_value;
    assign o_item.last = i_last_point;
    assign o_item.drop = w_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            if (i_last_point) begin
                r_cnt <= '0;
            end else if (!w_drop) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end
endmodule

// File: hdl/qlsf_fifo.sv
// Two-entry queue between the front end and the accumulator.
// Depends on qlsf_pkg.
module qlsf_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qlsf_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output qlsf_pkg::t_item o_item
);
    qlsf_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: hdl/qlsf_accum.sv
// Accumulator: power sums of one point set through a shared multiplier.
// Depends on qlsf_pkg; hands finished sets to qlsf_solve.
module qlsf_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  qlsf_pkg::t_item i_item,
    input  logic            i_ready,
    output logic            o_pop,
    output logic            o_start,
    output qlsf_pkg::t_sums o_sums
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_HAND = 2'd2;

    logic [1:0]                            r_state;
    logic [2:0]                            r_k;
    qlsf_pkg::t_item                       r_it;
    logic signed [23:0]                    r_x2;
    logic [qlsf_pkg::CNT_W-1:0]            r_cnt;
    logic signed [qlsf_pkg::SX_W-1:0]      r_sx;
    logic signed [qlsf_pkg::SX2_W-1:0]     r_sx2;
    logic signed [qlsf_pkg::SX3_W-1:0]     r_sx3;
    logic signed [qlsf_pkg::SX4_W-1:0]     r_sx4;
    logic signed [qlsf_pkg::SY_W-1:0]      r_sy;
    logic signed [qlsf_pkg::SXY_W-1:0]     r_sxy;
    logic signed [qlsf_pkg::SX2Y_W-1:0]    r_sx2y;
    logic                                  r_dropped;

    logic signed [23:0] w_opa;
    logic signed [23:0] w_opb;
    logic signed [47:0] w_prod;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_start = (r_state == S_HAND) && i_ready;

    assign o_sums.cnt     = r_cnt;
    assign o_sums.sx      = r_sx;
    assign o_sums.sx2     = r_sx2;
    assign o_sums.sx3     = r_sx3;
    assign o_sums.sx4     = r_sx4;
    assign o_sums.sy      = r_sy;
    assign o_sums.sxy     = r_sxy;
    assign o_sums.sx2y    = r_sx2y;
    assign o_sums.dropped = r_dropped;

    always_comb begin
        w_opa = (r_k < 3'd2) ? 24'(r_it.x) : r_x2;
        case (r_k)
            3'd0:    w_opb = 24'(r_it.x);
            3'd1:    w_opb = 24'(r_it.y);
            3'd2:    w_opb = 24'(r_it.x);
            3'd3:    w_opb = 24'(r_it.y);
            default: w_opb = r_x2;
        endcase
        w_prod = w_opa * w_opb;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it <= i_item;
        end
        if (r_state == S_MUL && r_k == 3'd0) begin
            r_x2 <= w_prod[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_cnt     <= '0;
            r_sx      <= '0;
            r_sx2     <= '0;
            r_sx3     <= '0;
            r_sx4     <= '0;
            r_sy      <= '0;
            r_sxy     <= '0;
            r_sx2y    <= '0;
            r_dropped <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_k <= '0;
                        if (i_item.drop) begin
                            r_dropped <= 1'b1;
                            r_state   <= i_item.last ? S_HAND : S_IDLE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_k <= r_k + 3'd1;
                    case (r_k)
                        3'd0: begin
                            r_cnt <= r_cnt + qlsf_pkg::CNT_W'(1);
                            r_sx  <= r_sx + qlsf_pkg::SX_W'(r_it.x);
                            r_sy  <= r_sy + qlsf_pkg::SY_W'(r_it.y);
                            r_sx2 <= r_sx2 + qlsf_pkg::SX2_W'(w_prod);
                        end
                        3'd1: r_sxy  <= r_sxy + qlsf_pkg::SXY_W'(w_prod);
                        3'd2: r_sx3  <= r_sx3 + qlsf_pkg::SX3_W'(w_prod);
                        3'd3: r_sx2y <= r_sx2y + qlsf_pkg::SX2Y_W'(w_prod);
                        default: begin
                            r_sx4   <= r_sx4 + qlsf_pkg::SX4_W'(w_prod);
                            r_state <= r_it.last ? S_HAND : S_IDLE;
                        end
                    endcase
                end
                S_HAND: begin
                    if (i_ready) begin
                        r_cnt     <= '0;
                        r_sx      <= '0;
                        r_sx2     <= '0;
                        r_sx3     <= '0;
                        r_sx4     <= '0;
                        r_sy      <= '0;
                        r_sxy     <= '0;
                        r_sx2y    <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/qlsf_solve.sv
// Solver: cofactors, determinant and numerators by a serial shift-add MAC,
// then a restoring divider per coefficient. Depends on qlsf_pkg.
module qlsf_solve (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  qlsf_pkg::t_sums                     i_sums,
    output logic                                o_ready,
    output logic                                o_done,
    output logic signed [qlsf_pkg::COEF_W-1:0]  o_coef_const,
    output logic signed [qlsf_pkg::COEF_W-1:0]  o_coef_linear,
    output logic signed [qlsf_pkg::COEF_W-1:0]  o_coef_square,
    output logic [qlsf_pkg::ST_W-1:0]           o_status
);
    localparam int A_W   = 108;
    localparam int B_W   = 54;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = P_W + 2;
    localparam int DIV_W = ACC_W + 36;
    localparam int Q_W   = 33;
    localparam int CW    = qlsf_pkg::COEF_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_DIVP = 3'd4;
    localparam logic [2:0] S_DIVS = 3'd5;
    localparam logic [2:0] S_DFIN = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [3:0] A_S0 = 4'd0;
    localparam logic [3:0] A_S1 = 4'd1;
    localparam logic [3:0] A_S2 = 4'd2;
    localparam logic [3:0] A_S3 = 4'd3;
    localparam logic [3:0] A_S4 = 4'd4;
    localparam logic [3:0] A_C00 = 4'd5;
    localparam logic [3:0] A_C01 = 4'd6;
    localparam logic [3:0] A_C02 = 4'd7;
    localparam logic [3:0] A_C11 = 4'd8;
    localparam logic [3:0] A_C12 = 4'd9;
    localparam logic [3:0] A_C22 = 4'd10;

    localparam logic [2:0] B_S0 = 3'd0;
    localparam logic [2:0] B_S1 = 3'd1;
    localparam logic [2:0] B_S2 = 3'd2;
    localparam logic [2:0] B_S3 = 3'd3;
    localparam logic [2:0] B_S4 = 3'd4;
    localparam logic [2:0] B_T0 = 3'd5;
    localparam logic [2:0] B_T1 = 3'd6;
    localparam logic [2:0] B_T2 = 3'd7;

    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_C00  = 4'd1;
    localparam logic [3:0] D_C01  = 4'd2;
    localparam logic [3:0] D_C02  = 4'd3;
    localparam logic [3:0] D_C11  = 4'd4;
    localparam logic [3:0] D_C12  = 4'd5;
    localparam logic [3:0] D_C22  = 4'd6;
    localparam logic [3:0] D_DET  = 4'd7;
    localparam logic [3:0] D_Q0   = 4'd8;
    localparam logic [3:0] D_Q1   = 4'd9;
    localparam logic [3:0] D_Q2   = 4'd10;

    localparam logic [4:0] LAST_STEP = 5'd23;

    typedef struct packed {
        logic [3:0] a;
        logic [2:0] b;
        logic       sub;
        logic       first;
        logic [3:0] dest;
    } t_step;

    function automatic t_step f_step(input logic [4:0] idx);
        t_step s;
        unique case (idx)
            5'd0:  s = '{A_S2,  B_S4, 1'b0, 1'b1, D_NONE};
            5'd1:  s = '{A_S3,  B_S3, 1'b1, 1'b0, D_C00};
            5'd2:  s = '{A_S2,  B_S3, 1'b0, 1'b1, D_NONE};
            5'd3:  s = '{A_S1,  B_S4, 1'b1, 1'b0, D_C01};
            5'd4:  s = '{A_S1,  B_S3, 1'b0, 1'b1, D_NONE};
            5'd5:  s = '{A_S2,  B_S2, 1'b1, 1'b0, D_C02};
            5'd6:  s = '{A_S0,  B_S4, 1'b0, 1'b1, D_NONE};
            5'd7:  s = '{A_S2,  B_S2, 1'b1, 1'b0, D_C11};
            5'd8:  s = '{A_S1,  B_S2, 1'b0, 1'b1, D_NONE};
            5'd9:  s = '{A_S0,  B_S3, 1'b1, 1'b0, D_C12};
            5'd10: s = '{A_S0,  B_S2, 1'b0, 1'b1, D_NONE};
            5'd11: s = '{A_S1,  B_S1, 1'b1, 1'b0, D_C22};
            5'd12: s = '{A_C00, B_S0, 1'b0, 1'b1, D_NONE};
            5'd13: s = '{A_C01, B_S1, 1'b0, 1'b0, D_NONE};
            5'd14: s = '{A_C02, B_S2, 1'b0, 1'b0, D_DET};
            5'd15: s = '{A_C00, B_T0, 1'b0, 1'b1, D_NONE};
            5'd16: s = '{A_C01, B_T1, 1'b0, 1'b0, D_NONE};
            5'd17: s = '{A_C02, B_T2, 1'b0, 1'b0, D_Q0};
            5'd18: s = '{A_C01, B_T0, 1'b0, 1'b1, D_NONE};
            5'd19: s = '{A_C11, B_T1, 1'b0, 1'b0, D_NONE};
            5'd20: s = '{A_C12, B_T2, 1'b0, 1'b0, D_Q1};
            5'd21: s = '{A_C02, B_T0, 1'b0, 1'b1, D_NONE};
            5'd22: s = '{A_C12, B_T1, 1'b0, 1'b0, D_NONE};
            5'd23: s = '{A_C22, B_T2, 1'b0, 1'b0, D_Q2};
            default: s = '{A_S0, B_S0, 1'b0, 1'b1, D_NONE};
        endcase
        return s;
    endfunction

    logic [2:0]               r_state;
    logic [4:0]               r_step;
    qlsf_pkg::t_sums          r_in;
    logic signed [A_W-1:0]    r_cf [6];
    logic [P_W-1:0]           r_ma;
    logic [B_W-1:0]           r_mb;
    logic [P_W-1:0]           r_prod;
    logic                     r_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_det;
    logic [1:0]               r_qi;
    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-1:0]         r_dsh;
    logic [Q_W-1:0]           r_q;
    logic [5:0]               r_bit;
    logic                     r_ovf;
    logic                     r_qneg;
    logic signed [CW-1:0]     r_coef [3];
    logic [qlsf_pkg::ST_W-1:0] r_status;
    logic                     r_done;

    t_step                    w_st;
    logic signed [B_W-1:0]    w_b [8];
    logic signed [A_W-1:0]    w_a [11];
    logic signed [A_W-1:0]    w_asel;
    logic signed [B_W-1:0]    w_bsel;
    logic [A_W-1:0]           w_absa;
    logic [B_W-1:0]           w_absb;
    logic signed [ACC_W-1:0]  w_p;
    logic signed [ACC_W-1:0]  w_acc;
    logic [ACC_W-1:0]         w_absn;
    logic [ACC_W-1:0]         w_absd;
    logic [DIV_W-1:0]         w_nsh;
    logic                     w_ge;
    logic [2:0]               w_ci;
    logic signed [CW-1:0]     w_coef;

    assign w_st  = f_step(r_step);
    assign w_b[0] = B_W'(r_in.cnt);
    assign w_b[1] = B_W'(r_in.sx);
    assign w_b[2] = B_W'(r_in.sx2);
    assign w_b[3] = B_W'(r_in.sx3);
    assign w_b[4] = B_W'(r_in.sx4);
    assign w_b[5] = B_W'(r_in.sy);
    assign w_b[6] = B_W'(r_in.sxy);
    assign w_b[7] = B_W'(r_in.sx2y);

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_a[i] = A_W'(w_b[i]);
        end
        for (int i = 0; i < 6; i++) begin
            w_a[i+5] = r_cf[i];
        end
    end

    assign w_asel = (w_st.a > A_C22) ? w_a[0] : w_a[w_st.a];
    assign w_bsel = w_b[w_st.b];
    assign w_absa = w_asel[A_W-1] ? A_W'(-w_asel) : A_W'(w_asel);
    assign w_absb = w_bsel[B_W-1] ? B_W'(-w_bsel) : B_W'(w_bsel);

    assign w_p   = r_neg ? -$signed(ACC_W'(r_prod)) : $signed(ACC_W'(r_prod));
    assign w_acc = (w_st.first ? ACC_W'(0) : r_acc) + w_p;
    assign w_ci  = 3'(w_st.dest - D_C00);

    assign w_absn = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_absd = r_det[ACC_W-1] ? ACC_W'(-r_det) : ACC_W'(r_det);

    always_comb begin
        case (r_qi)
            2'd0:    w_nsh = DIV_W'(w_absn) << 11;
            2'd1:    w_nsh = DIV_W'(w_absn) << 17;
            default: w_nsh = DIV_W'(w_absn) << 23;
        endcase
    end

    assign w_ge = (r_rem >= r_dsh);

    always_comb begin
        if (r_ovf) begin
            w_coef = r_qneg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else if (!r_qneg) begin
            w_coef = (r_q > Q_W'({1'b0, {(CW-1){1'b1}}})) ? {1'b0, {(CW-1){1'b1}}}
                                                           : $signed(r_q[CW-1:0]);
        end else begin
            w_coef = (r_q > Q_W'({1'b1, {(CW-1){1'b0}}})) ? {1'b1, {(CW-1){1'b0}}}
                                                           : $signed(-r_q[CW-1:0]);
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_done        = r_done;
    assign o_coef_const  = r_coef[0];
    assign o_coef_linear = r_coef[1];
    assign o_coef_square = r_coef[2];
    assign o_status      = r_status;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_in <= i_sums;
        end
        if (r_state == S_LOAD) begin
            r_ma   <= P_W'(w_absa);
            r_mb   <= w_absb;
            r_prod <= '0;
            r_neg  <= w_asel[A_W-1] ^ w_bsel[B_W-1] ^ w_st.sub;
        end
        if (r_state == S_MUL && r_mb != '0) begin
            if (r_mb[0]) begin
                r_prod <= r_prod + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
        if (r_state == S_ACC) begin
            r_acc <= w_acc;
            if (w_st.dest >= D_C00 && w_st.dest <= D_C22) begin
                r_cf[w_ci] <= w_acc[A_W-1:0];
            end
            if (w_st.dest == D_DET) begin
                r_det <= w_acc;
            end
            if (w_st.dest >= D_Q0) begin
                r_qi <= 2'(w_st.dest - D_Q0);
            end
        end
        if (r_state == S_DIVP) begin
            r_rem  <= w_nsh + DIV_W'(w_absd);
            r_dsh  <= DIV_W'(w_absd) << 34;
            r_q    <= '0;
            r_bit  <= 6'd33;
            r_ovf  <= 1'b0;
            r_qneg <= r_acc[ACC_W-1] ^ r_det[ACC_W-1];
        end
        if (r_state == S_DIVS) begin
            r_dsh <= r_dsh >> 1;
            r_bit <= r_bit - 6'd1;
            if (r_bit == 6'd33) begin
                r_ovf <= w_ge;
            end else begin
                r_q <= {r_q[Q_W-2:0], w_ge};
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_done   <= 1'b0;
            r_status <= qlsf_pkg::ST_OK;
            for (int i = 0; i < 3; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_step  <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: r_state <= S_MUL;
                S_MUL: begin
                    if (r_mb == '0) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (w_st.dest == D_DET && w_acc == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_coef[i] <= '0;
                        end
                        r_status <= qlsf_pkg::ST_SINGULAR;
                        r_state  <= S_OUT;
                    end else if (w_st.dest >= D_Q0) begin
                        r_state <= S_DIVP;
                    end else begin
                        r_step  <= r_step + 5'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_DIVP: r_state <= S_DIVS;
                S_DIVS: begin
                    if ((r_bit == 6'd33 && w_ge) || r_bit == 6'd0) begin
                        r_state <= S_DFIN;
                    end
                end
                S_DFIN: begin
                    r_coef[r_qi] <= w_coef;
                    if (r_step == LAST_STEP) begin
                        r_status <= r_in.dropped ? qlsf_pkg::ST_OVERFLOW : qlsf_pkg::ST_OK;
                        r_state  <= S_OUT;
                    end else begin
                        r_step  <= r_step + 5'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/quadratic_least_squares_fit_top.sv
// Quadratic least-squares fit: point intake, two-entry queue, accumulator, solver.
// Depends on qlsf_pkg, qlsf_front, qlsf_fifo, qlsf_accum, qlsf_solve.
// The accumulator takes one point at a time: each accepted point runs serially
// through its one shared 24x24 multiplier, a dropped point is only popped; busy
// rises when the queue is full. After the last point the solver runs 24 serial MACs,
// then three divisions; o_done pulses one cycle. Sync reset clears state, sums, outputs.
module quadratic_least_squares_fit_top #(
    parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qlsf_pkg::XW-1:0]      i_x_value,
    input  logic signed [qlsf_pkg::XW-1:0]      i_y_value,
    input  logic                                i_last_point,
    output logic                                o_done,
    output logic signed [qlsf_pkg::COEF_W-1:0]  o_coef_const,
    output logic signed [qlsf_pkg::COEF_W-1:0]  o_coef_linear,
    output logic signed [qlsf_pkg::COEF_W-1:0]  o_coef_square,
    output logic [qlsf_pkg::ST_W-1:0]           o_status
);
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    logic            w_ready;
    logic            w_start;
    qlsf_pkg::t_item w_in_item;
    qlsf_pkg::t_item w_q_item;
    qlsf_pkg::t_sums w_sums;

    qlsf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_x_value    (i_x_value),
        .i_y_value    (i_y_value),
        .i_last_point (i_last_point),
        .i_full       (w_full),
        .busy         (busy),
        .o_push       (w_push),
        .o_item       (w_in_item)
    );

    qlsf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_q_item)
    );

    qlsf_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_q_item),
        .i_ready (w_ready),
        .o_pop   (w_pop),
        .o_start (w_start),
        .o_sums  (w_sums)
    );

    qlsf_solve u_solve (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_sums        (w_sums),
        .o_ready       (w_ready),
        .o_done        (o_done),
        .o_coef_const  (o_coef_const),
        .o_coef_linear (o_coef_linear),
        .o_coef_square (o_coef_square),
        .o_status      (o_status)
    );
endmodule
